### design/fspc_pkg.sv
// fspc_pkg: types and constants for the framed serial packet checker
// no dependencies; imported by framed_serial_packet_checker
`timescale 1ns / 1ps

package fspc_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] MARKER_AT_RESET = 8'h99;
  localparam logic [BYTE_W-1:0] MIN_FRAME       = 8'd4;
  localparam logic [BYTE_W-1:0] CHECK_BYTES     = 8'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic              checksum_ok;
    logic              frame_last;
    logic              frame_first;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] frame_byte;
  } result_t;

endpackage

### design/framed_serial_packet_checker.sv
// framed_serial_packet_checker: frame hunter and fletcher-style checksum check
// depends on fspc_pkg (phase codes, result type, constants)
`timescale 1ns / 1ps

// Usage
//   in_*  : one received link byte per item (in_tdata = rx_byte).
//   out_* : one item per frame byte; out_tdata = {byte_index, frame_byte},
//           out_tlast = frame_last, out_tuser = {checksum_ok, frame_first}.
//   cfg_* : cfg_we writes cfg_wdata into the start marker; write only while idle.
// A start marker always opens a new frame at index 0. Bytes seen while
// hunting give no output item. A length byte below 4 ends the frame as bad.
// Each result is registered in the output register, or in the skid register
// when the receiver stalls; throughput is one byte per cycle while it accepts.
// When the receiver stalls, a one-entry skid register takes one more result,
// then in_tready drops until the skid entry moves into the output register.
// Reset (synchronous, rst_n low) returns to hunting, empties both output
// registers and restores the start marker to 0x99.

module framed_serial_packet_checker
  import fspc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [15:8] byte_index
  output logic        out_tlast,  // frame_last
  output logic [1:0]  out_tuser   // [0] frame_first, [1] checksum_ok
);

  logic [BYTE_W-1:0] marker_r;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] position_r, position_nxt;
  logic [BYTE_W-1:0] frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0] sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0] sum_b_r, sum_b_nxt;
  logic              first_ok_r, first_ok_nxt;

  result_t           out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;
  logic              res_valid;

  logic              accept;
  logic              is_marker;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] len_m2;
  logic [BYTE_W-1:0] sum_a_add;
  logic [BYTE_W-1:0] sum_b_add;
  logic              load_out;

  assign b         = in_tdata;
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign is_marker = (b == marker_r);
  assign len_m2    = frame_length_r - CHECK_BYTES;
  assign sum_a_add = sum_a_r + b;
  assign sum_b_add = sum_b_r + sum_a_add;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_marker) begin
      phase_nxt = PH_LEN;
    end else begin
      case (phase_r)
        PH_LEN: begin
          phase_nxt = (b < MIN_FRAME) ? PH_HUNT : PH_BODY;
        end
        PH_BODY: begin
          if (position_r > len_m2) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    position_nxt     = position_r;
    frame_length_nxt = frame_length_r;
    sum_a_nxt        = sum_a_r;
    sum_b_nxt        = sum_b_r;
    first_ok_nxt     = first_ok_r;
    res_valid        = 1'b0;
    res.frame_byte   = b;
    res.byte_index   = position_r;
    res.frame_first  = 1'b0;
    res.frame_last   = 1'b0;
    res.checksum_ok  = 1'b0;
    if (is_marker) begin
      position_nxt    = 8'd1;
      sum_a_nxt       = '0;
      sum_b_nxt       = '0;
      first_ok_nxt    = 1'b0;
      res_valid       = 1'b1;
      res.byte_index  = '0;
      res.frame_first = 1'b1;
    end else begin
      case (phase_r)
        PH_LEN: begin
          res_valid      = 1'b1;
          res.byte_index = 8'd1;
          if (b < MIN_FRAME) begin
            position_nxt   = '0;
            res.frame_last = 1'b1;
          end else begin
            frame_length_nxt = b;
            sum_a_nxt        = b;
            sum_b_nxt        = b;
            position_nxt     = 8'd2;
          end
        end
        PH_BODY: begin
          res_valid = 1'b1;
          if (position_r < len_m2) begin
            sum_a_nxt    = sum_a_add;
            sum_b_nxt    = sum_b_add;
            position_nxt = position_r + 8'd1;
          end else if (position_r == len_m2) begin
            first_ok_nxt = (b == sum_a_r);
            position_nxt = position_r + 8'd1;
          end else begin
            position_nxt    = '0;
            res.frame_last  = 1'b1;
            res.checksum_ok = first_ok_r && (b == sum_b_r);
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r       <= MARKER_AT_RESET;
      phase_r        <= PH_HUNT;
      position_r     <= '0;
      frame_length_r <= '0;
      sum_a_r        <= '0;
      sum_b_r        <= '0;
      first_ok_r     <= 1'b0;
    end else begin
      if (cfg_we) marker_r <= cfg_wdata;
      if (accept) begin
        phase_r        <= phase_nxt;
        position_r     <= position_nxt;
        frame_length_r <= frame_length_nxt;
        sum_a_r        <= sum_a_nxt;
        sum_b_r        <= sum_b_nxt;
        first_ok_r     <= first_ok_nxt;
      end
    end
  end

  // output register with skid entry
  assign load_out = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.byte_index, out_r.frame_byte};
  assign out_tlast  = out_r.frame_last;
  assign out_tuser  = {out_r.checksum_ok, out_r.frame_first};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while output register is empty");

  a_ok_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser[1]) |-> out_tlast)
    else $error("checksum_ok set on a byte that is not frame_last");

  a_first_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser[0]) |-> (out_tdata[15:8] == 8'd0 && !out_tlast))
    else $error("start marker item with nonzero index or frame_last");

  a_body_length: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (frame_length_r >= MIN_FRAME))
    else $error("frame body entered with a short length");

endmodule

### tb/sv/fspc_frame_monitor.sv
// fspc_frame_monitor: watches the byte, result and marker ports of the frame checker,
// predicts each frame item and compares it field by field against the result stream
// depends on fspc_pkg (phase codes, result type, constants)
`timescale 1ns / 1ps

module fspc_frame_monitor
  import fspc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] frame_byte, [15:8] byte_index
  input  logic        out_tlast,  // frame_last
  input  logic [1:0]  out_tuser,  // [0] frame_first, [1] checksum_ok
  output int          mismatches,
  output int          pending
);

  logic [7:0] marker;
  phase_t     hunt_phase;
  logic [7:0] position;
  logic [7:0] frame_len;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  bit         first_ok;

  result_t    expected_items[$];
  result_t    predicted;
  result_t    observed;
  result_t    oldest;
  bit         produced;
  int         fail_count = 0;

  task automatic track_rx(input logic [7:0] rx, output bit emitted, output result_t r);
    logic [7:0] check_at;
    check_at = frame_len - CHECK_BYTES;
    r = '0;
    r.frame_byte = rx;
    emitted = 1'b1;
    if (rx == marker) begin
      hunt_phase = PH_LEN;
      position = 8'd1;
      sum_a = '0;
      sum_b = '0;
      first_ok = 1'b0;
      r.frame_first = 1'b1;
    end else if (hunt_phase == PH_LEN) begin
      r.byte_index = 8'd1;
      if (rx < MIN_FRAME) begin
        hunt_phase = PH_HUNT;
        position = '0;
        r.frame_last = 1'b1;
      end else begin
        frame_len = rx;
        sum_a = rx;
        sum_b = rx;
        position = 8'd2;
        hunt_phase = PH_BODY;
      end
    end else if (hunt_phase == PH_BODY) begin
      r.byte_index = position;
      if (position < check_at) begin
        sum_a = sum_a + rx;
        sum_b = sum_b + sum_a;
        position = position + 8'd1;
      end else if (position == check_at) begin
        first_ok = (rx == sum_a);
        position = position + 8'd1;
      end else begin
        r.frame_last = 1'b1;
        r.checksum_ok = first_ok && (rx == sum_b);
        hunt_phase = PH_HUNT;
        position = '0;
      end
    end else begin
      // bytes between frames, and the spare phase code, are dropped
      hunt_phase = PH_HUNT;
      emitted = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      marker = MARKER_AT_RESET;
      hunt_phase = PH_HUNT;
      position = '0;
      frame_len = '0;
      sum_a = '0;
      sum_b = '0;
      first_ok = 1'b0;
      expected_items.delete();
    end else begin
      if (cfg_we) begin
        marker = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        observed.frame_byte = out_tdata[7:0];
        observed.byte_index = out_tdata[15:8];
        observed.frame_last = out_tlast;
        observed.frame_first = out_tuser[0];
        observed.checksum_ok = out_tuser[1];
        if (expected_items.size() == 0) begin
          fail_count++;
          $display("%0t: item expected none actual %0h", $time, observed);
        end else begin
          oldest = expected_items.pop_front();
          check_field("frame_byte", int'(oldest.frame_byte), int'(observed.frame_byte));
          check_field("byte_index", int'(oldest.byte_index), int'(observed.byte_index));
          check_field("frame_first", int'(oldest.frame_first), int'(observed.frame_first));
          check_field("frame_last", int'(oldest.frame_last), int'(observed.frame_last));
          check_field("checksum_ok", int'(oldest.checksum_ok), int'(observed.checksum_ok));
        end
      end
      if (in_tvalid && in_tready) begin
        track_rx(in_tdata, produced, predicted);
        if (produced) begin
          expected_items = {expected_items, predicted};
        end
      end
    end
    mismatches <= fail_count;
    pending <= expected_items.size();
  end

endmodule

### tb/sv/framed_serial_packet_checker_tb.sv
// framed_serial_packet_checker_tb: clock, reset and framed byte stimulus for the checker
// depends on fspc_pkg, framed_serial_packet_checker and fspc_frame_monitor
`timescale 1ns / 1ps

module framed_serial_packet_checker_tb
  import fspc_pkg::*;
();

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_A,
    FRAME_BAD_B,
    FRAME_CUT,
    FRAME_SHORT
  } frame_kind_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_RUN = 175;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] frame_byte, [15:8] byte_index
  logic        out_tlast;        // frame_last
  logic [1:0]  out_tuser;        // [0] frame_first, [1] checksum_ok

  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          frame_items;
  logic [7:0]  marker_now = MARKER_AT_RESET;
  int          pick;

  framed_serial_packet_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  fspc_frame_monitor frame_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] len, input frame_kind_t kind);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] pay;
    int         cut_at;
    int         k;
    sum_a = len;
    sum_b = len;
    cut_at = (kind == FRAME_CUT && len > 2) ? $urandom_range(2, len - 1) : 256;
    send_byte(marker_now);
    send_byte(len);
    frame_items += 2;
    if (kind != FRAME_SHORT) begin
      for (k = 2; k < len && k < cut_at; k++) begin
        if (k < len - 2) begin
          pay = 8'($urandom_range(255));
          sum_a = sum_a + pay;
          sum_b = sum_b + sum_a;
        end else if (k == len - 2) begin
          pay = (kind == FRAME_BAD_A) ? sum_a ^ 8'($urandom_range(1, 255)) : sum_a;
        end else begin
          pay = (kind == FRAME_BAD_B) ? sum_b ^ 8'($urandom_range(1, 255)) : sum_b;
        end
        send_byte(pay);
        frame_items++;
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_now = v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hunting noise, short length, minimum frames, bad sums, restart
    frame_items = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd3, FRAME_SHORT);
    send_frame(8'd4, FRAME_GOOD);
    send_frame(8'd4, FRAME_BAD_A);
    send_frame(8'd4, FRAME_BAD_B);
    send_byte(marker_now);
    send_byte(8'd5);
    send_byte(8'hFF);
    send_byte(8'h04);
    send_byte(8'h09);
    send_byte(marker_now);
    send_byte(8'd7);
    send_byte(8'h00);
    send_frame(8'd4, FRAME_GOOD);
    settle();

    for (int run = 0; run < 4; run++) begin
      case (run)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 60;
          stall_pct = 0;
          write_marker(8'h00);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 60;
          write_marker(8'hFF);
        end
        default: begin
          idle_pct = 8;
          stall_pct = 8;
          write_marker(8'($urandom_range(255)));
        end
      endcase
      frame_items = 0;
      if (run == 0) begin
        send_frame(8'd255, FRAME_GOOD);
      end
      while (frame_items < ITEMS_PER_RUN) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame(($urandom_range(9) == 0) ? 8'($urandom_range(21, 64))
                                              : 8'($urandom_range(4, 20)), FRAME_GOOD);
        end else if (pick < 78) begin
          send_frame(8'($urandom_range(4, 20)), FRAME_BAD_A);
        end else if (pick < 84) begin
          send_frame(8'($urandom_range(4, 20)), FRAME_BAD_B);
        end else if (pick < 90) begin
          send_frame(8'($urandom_range(4, 20)), FRAME_CUT);
        end else if (pick < 94) begin
          send_frame(8'($urandom_range(0, 3)), FRAME_SHORT);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
